// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, sampled on the rising clock edge, off while reset is low.
`define VRH_ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vrh: property failed");

// Condition that must hold at every clock edge out of reset.
`define VRH_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    `VRH_ASSERT_PROP(lbl, clk, rst_n, (expr))

`endif

// ===== src/vrh_pkg.sv =====
// Types, constants and helper functions of the vessel reach Hamiltonian block.
package vrh_pkg;

    localparam int DATA_W     = 32;
    localparam int COEF_W     = 20;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_FRAC  = 16;
    localparam int TRIG_FRAC  = 30;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int CFG_IDX_W  = REG_IDX_W + 1;
    localparam int PIPE_DEPTH = 16;

    // round(2^32 / (2 pi)) and round(pi * 2^29)
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [30:0] PI_Q29         = 31'd1686629713;
    localparam logic [30:0] TRIG_ONE       = 31'(64'd1 << TRIG_FRAC);

    localparam logic signed [63:0] DATA_MAX = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam logic signed [63:0] DATA_MIN = -(64'sd1 <<< (DATA_W - 1));

    // Exact reciprocal multipliers for 32-bit dividends.
    localparam int DIV_IN_W = 32;
    localparam int SH_D42 = DIV_IN_W + $clog2(42);
    localparam int SH_D56 = DIV_IN_W + $clog2(56);
    localparam int SH_D20 = DIV_IN_W + $clog2(20);
    localparam int SH_D30 = DIV_IN_W + $clog2(30);
    localparam int SH_D6  = DIV_IN_W + $clog2(6);
    localparam int SH_D12 = DIV_IN_W + $clog2(12);
    localparam logic [32:0] MG_D42 = 33'(((66'd1 << SH_D42) + 66'd41) / 66'd42);
    localparam logic [32:0] MG_D56 = 33'(((66'd1 << SH_D56) + 66'd55) / 66'd56);
    localparam logic [32:0] MG_D20 = 33'(((66'd1 << SH_D20) + 66'd19) / 66'd20);
    localparam logic [32:0] MG_D30 = 33'(((66'd1 << SH_D30) + 66'd29) / 66'd30);
    localparam logic [32:0] MG_D6  = 33'(((66'd1 << SH_D6) + 66'd5) / 66'd6);
    localparam logic [32:0] MG_D12 = 33'(((66'd1 << SH_D12) + 66'd11) / 66'd12);

    typedef logic [COEF_W-1:0]        t_coef;
    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SURGE_LIN,
        REG_SURGE_QUAD,
        REG_SWAY,
        REG_YAW_LIN,
        REG_YAW_QUAD,
        REG_SURGE_DIST,
        REG_SWAY_DIST,
        REG_YAW_DIST
    } t_reg_idx;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    localparam t_coef COEF_RESET [NUM_REGS] = '{
        20'd6739, 20'd1940, 20'd7039, 20'd22794,
        20'd19661, 20'd32768, 20'd16384, 20'd6554
    };

    typedef struct packed {
        t_data grad_x;
        t_data grad_y;
        t_data grad_surge;
        t_data grad_sway;
        t_data grad_heading;
        t_data grad_yaw;
        t_data surge;
        t_data sway;
        t_data yaw_rate;
    } t_item;

    typedef struct packed {
        t_quad quad;
        logic  mirror;
    } t_trig;

    // Floor of x / d through the reciprocal multiplier of d.
    function automatic logic [31:0] div_magic(input logic [31:0] x,
                                              input logic [32:0] mg,
                                              input int unsigned sh);
        logic [64:0] prod;
        prod = {33'd0, x} * {32'd0, mg};
        return 32'(prod >> sh);
    endfunction

    function automatic t_data sat_data(input logic signed [63:0] x);
        t_data res;
        if (x > DATA_MAX) begin
            res = t_data'(DATA_MAX);
        end else if (x < DATA_MIN) begin
            res = t_data'(DATA_MIN);
        end else begin
            res = t_data'(x);
        end
        return res;
    endfunction

endpackage

// ===== src/vessel_reach_hamiltonian.sv =====
// Top level of the vessel reach Hamiltonian pipeline.
//
// Usage: each grid point is one input word: six gradient components, the
// surge, sway, heading and yaw rate of the point, and an end-of-batch flag.
// A word is taken at a rising edge where start is high and busy is low. The
// block never raises busy, so a new word can be offered in every cycle and
// the throughput is one grid point per clock.
// Every word yields exactly one result word: o_ham_value and o_last_out are
// shown for a single cycle with o_valid high. The pipeline depth is set by
// the heading path: the phase, the angle and its square, six stages of sine
// and cosine series, the quadrant rotation, the rotation products, the
// velocity sums, the gradient products, a two level adder tree and the
// final saturation, one register each.
// The receiver cannot stall, so results never back up and nothing is held.
// The eight damping and disturbance registers are written on the config
// channel (index plus data, valid and ready); ready is always high and
// indexes past the last register are dropped. Write them only while no
// points are in flight.
// Reset is synchronous and active low: it empties the pipeline and loads
// the default coefficients; results of words in flight are discarded.
module vessel_reach_hamiltonian (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [vrh_pkg::DATA_W-1:0] i_grad_x,
    input  logic signed [vrh_pkg::DATA_W-1:0] i_grad_y,
    input  logic signed [vrh_pkg::DATA_W-1:0] i_grad_surge,
    input  logic signed [vrh_pkg::DATA_W-1:0] i_grad_sway,
    input  logic signed [vrh_pkg::DATA_W-1:0] i_grad_heading,
    input  logic signed [vrh_pkg::DATA_W-1:0] i_grad_yaw,
    input  logic signed [vrh_pkg::DATA_W-1:0] i_surge_speed,
    input  logic signed [vrh_pkg::DATA_W-1:0] i_sway_speed,
    input  logic signed [vrh_pkg::DATA_W-1:0] i_heading,
    input  logic signed [vrh_pkg::DATA_W-1:0] i_yaw_rate,
    input  logic                             i_last_point,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vrh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vrh_pkg::COEF_W-1:0]       i_cfg_data,
    output logic                             o_valid,
    output logic signed [vrh_pkg::DATA_W-1:0] o_ham_value,
    output logic                             o_last_out
);
    import vrh_pkg::*;

    // Configuration registers.
    t_coef r_coef [NUM_REGS];

    // Control: one valid bit per stage, and the batch flag alongside.
    logic [PIPE_DEPTH:1] r_vld;
    logic [PIPE_DEPTH:1] r_lst;
    logic                accept;

    // Delay lines for operands that are used several stages later.
    t_item       r_item [1:12];
    t_trig       r_trg  [2:9];
    logic [30:0] r_xr   [2:8];
    logic [31:0] r_x2   [3:8];

    // Trigonometric path.
    logic [31:0]        r_phase;
    logic [30:0]        r_ts1, r_tc1, r_ts2, r_tc2, r_ts3, r_tc3;
    logic [31:0]        r_ys1, r_yc1, r_ys2, r_yc2;
    logic signed [32:0] r_sin, r_cos;
    logic signed [33:0] r_sn, r_cs;
    logic signed [65:0] r_ucs, r_vsn, r_usn, r_vcs;
    t_data              r_fx, r_fy;

    // Damping path.
    logic signed [64:0] r_mu, r_mr;
    t_data              r_uu, r_rr;
    logic signed [52:0] r_au, r_buu, r_yvv, r_nr, r_nrr;
    t_data              r_fu, r_fv, r_fr;

    // Sum.
    logic signed [63:0] r_term [0:8];
    logic signed [63:0] r_grp  [0:2];
    logic signed [63:0] r_sum;
    t_data              r_ham;

    // Combinational intermediates.
    t_item              n_item;
    logic signed [62:0] s1_prod;
    logic [29:0]        s2_x;
    logic [60:0]        s2_prod;
    logic [61:0]        s3_prod;
    logic [62:0]        s5_ps, s5_pc, s7_ps, s7_pc, s9_pc;
    logic [61:0]        s9_ps;
    logic signed [32:0] s9_absu, s9_absr, n_cos;
    logic signed [33:0] s10_a, s10_b;
    logic signed [33:0] n_sn, n_cs;
    logic signed [66:0] s12_dx, s12_dy;
    logic signed [54:0] s12_fu, s12_fr;
    logic signed [53:0] s12_fv;
    logic signed [63:0] s13_t0, s13_t1, s13_t2, s13_t3, s13_t4, s13_t5;
    logic signed [32:0] s13_ap2, s13_ap3, s13_ap5;
    logic signed [53:0] s13_w2, s13_w3, s13_w5;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RESET;
        end else if (i_cfg_valid && o_cfg_ready &&
                     i_cfg_index < CFG_IDX_W'(NUM_REGS)) begin
            r_coef[i_cfg_index[REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-1:1], accept};
        end
    end

    // Stage 1: heading to phase in turns.
    assign s1_prod = i_heading * $signed({1'b0, INV_TWO_PI_Q32});

    always_comb begin
        n_item.grad_x       = i_grad_x;
        n_item.grad_y       = i_grad_y;
        n_item.grad_surge   = i_grad_surge;
        n_item.grad_sway    = i_grad_sway;
        n_item.grad_heading = i_grad_heading;
        n_item.grad_yaw     = i_grad_yaw;
        n_item.surge        = i_surge_speed;
        n_item.sway         = i_sway_speed;
        n_item.yaw_rate     = i_yaw_rate;
    end

    // Stage 2: mirror the quarter-turn fraction and scale it to radians.
    assign s2_x    = r_phase[29] ? 30'(TRIG_ONE - {1'b0, r_phase[29:0]}) : r_phase[29:0];
    assign s2_prod = s2_x * PI_Q29;

    // Stage 3: square of the angle.
    assign s3_prod = r_xr[2] * r_xr[2];

    // Stages 5 and 7: Horner products of the sine and cosine series.
    assign s5_ps = r_x2[4] * r_ts1;
    assign s5_pc = r_x2[4] * r_tc1;
    assign s7_ps = r_x2[6] * r_ts2;
    assign s7_pc = r_x2[6] * r_tc2;

    // Stage 9: last series products; the damping path starts here as well.
    assign s9_ps   = r_xr[8] * r_ts3;
    assign s9_pc   = r_x2[8] * r_tc3;
    assign n_cos   = $signed({2'b00, TRIG_ONE}) - $signed({2'b00, s9_pc[61:31]});
    assign s9_absu = (r_item[8].surge < 0) ? -33'(r_item[8].surge) : 33'(r_item[8].surge);
    assign s9_absr = (r_item[8].yaw_rate < 0) ? -33'(r_item[8].yaw_rate)
                                              : 33'(r_item[8].yaw_rate);

    // Stage 10: undo the mirror, then rotate into the quadrant.
    assign s10_a = r_trg[9].mirror ? 34'(r_cos) : 34'(r_sin);
    assign s10_b = r_trg[9].mirror ? 34'(r_sin) : 34'(r_cos);

    always_comb begin
        case (r_trg[9].quad)
            QUAD_I: begin
                n_sn = s10_a;
                n_cs = s10_b;
            end
            QUAD_II: begin
                n_sn = s10_b;
                n_cs = -s10_a;
            end
            QUAD_III: begin
                n_sn = -s10_a;
                n_cs = -s10_b;
            end
            default: begin
                n_sn = -s10_b;
                n_cs = s10_a;
            end
        endcase
    end

    // Stage 12: velocity components and damping forces.
    assign s12_dx = r_ucs - r_vsn;
    assign s12_dy = r_usn + r_vcs;
    assign s12_fu = -(r_au + r_buu);
    assign s12_fv = -r_yvv;
    assign s12_fr = -(r_nr + r_nrr);

    // Stage 13: gradient products and disturbance terms.
    assign s13_t0  = r_fx * r_item[12].grad_x;
    assign s13_t1  = r_fy * r_item[12].grad_y;
    assign s13_t2  = r_fu * r_item[12].grad_surge;
    assign s13_t3  = r_fv * r_item[12].grad_sway;
    assign s13_t4  = r_item[12].yaw_rate * r_item[12].grad_heading;
    assign s13_t5  = r_fr * r_item[12].grad_yaw;
    assign s13_ap2 = (r_item[12].grad_surge < 0) ? -33'(r_item[12].grad_surge)
                                                 : 33'(r_item[12].grad_surge);
    assign s13_ap3 = (r_item[12].grad_sway < 0) ? -33'(r_item[12].grad_sway)
                                                : 33'(r_item[12].grad_sway);
    assign s13_ap5 = (r_item[12].grad_yaw < 0) ? -33'(r_item[12].grad_yaw)
                                               : 33'(r_item[12].grad_yaw);
    assign s13_w2  = $signed({1'b0, r_coef[REG_SURGE_DIST]}) * s13_ap2;
    assign s13_w3  = $signed({1'b0, r_coef[REG_SWAY_DIST]}) * s13_ap3;
    assign s13_w5  = $signed({1'b0, r_coef[REG_YAW_DIST]}) * s13_ap5;

    always_ff @(posedge i_clk) begin
        // Delay lines.
        r_item[1] <= n_item;
        for (int k = 2; k <= 12; k++) begin
            r_item[k] <= r_item[k-1];
        end
        for (int k = 3; k <= 9; k++) begin
            r_trg[k] <= r_trg[k-1];
        end
        for (int k = 3; k <= 8; k++) begin
            r_xr[k] <= r_xr[k-1];
        end
        for (int k = 4; k <= 8; k++) begin
            r_x2[k] <= r_x2[k-1];
        end
        r_lst <= {r_lst[PIPE_DEPTH-1:1], i_last_point};

        // Heading path.
        r_phase       <= s1_prod[FRAC_BITS +: 32];
        r_trg[2]      <= '{quad: t_quad'(r_phase[31:30]), mirror: r_phase[29]};
        r_xr[2]       <= s2_prod[60:30];
        r_x2[3]       <= s3_prod[61:30];
        r_ts1         <= TRIG_ONE - 31'(div_magic(r_x2[3], MG_D42, SH_D42));
        r_tc1         <= TRIG_ONE - 31'(div_magic(r_x2[3], MG_D56, SH_D56));
        r_ys1         <= s5_ps[61:30];
        r_yc1         <= s5_pc[61:30];
        r_ts2         <= TRIG_ONE - 31'(div_magic(r_ys1, MG_D20, SH_D20));
        r_tc2         <= TRIG_ONE - 31'(div_magic(r_yc1, MG_D30, SH_D30));
        r_ys2         <= s7_ps[61:30];
        r_yc2         <= s7_pc[61:30];
        r_ts3         <= TRIG_ONE - 31'(div_magic(r_ys2, MG_D6, SH_D6));
        r_tc3         <= TRIG_ONE - 31'(div_magic(r_yc2, MG_D12, SH_D12));
        r_sin         <= $signed({1'b0, s9_ps[61:30]});
        r_cos         <= n_cos;
        r_sn          <= n_sn;
        r_cs          <= n_cs;
        r_ucs         <= r_item[10].surge * r_cs;
        r_vsn         <= r_item[10].sway * r_sn;
        r_usn         <= r_item[10].surge * r_sn;
        r_vcs         <= r_item[10].sway * r_cs;
        r_fx          <= sat_data(64'(s12_dx >>> TRIG_FRAC));
        r_fy          <= sat_data(64'(s12_dy >>> TRIG_FRAC));

        // Damping path.
        r_mu  <= s9_absu * r_item[8].surge;
        r_mr  <= s9_absr * r_item[8].yaw_rate;
        r_uu  <= sat_data(64'(r_mu >>> FRAC_BITS));
        r_rr  <= sat_data(64'(r_mr >>> FRAC_BITS));
        r_au  <= $signed({1'b0, r_coef[REG_SURGE_LIN]}) * r_item[10].surge;
        r_buu <= $signed({1'b0, r_coef[REG_SURGE_QUAD]}) * r_uu;
        r_yvv <= $signed({1'b0, r_coef[REG_SWAY]}) * r_item[10].sway;
        r_nr  <= $signed({1'b0, r_coef[REG_YAW_LIN]}) * r_item[10].yaw_rate;
        r_nrr <= $signed({1'b0, r_coef[REG_YAW_QUAD]}) * r_rr;
        r_fu  <= sat_data(64'(s12_fu >>> COEF_FRAC));
        r_fv  <= sat_data(64'(s12_fv >>> COEF_FRAC));
        r_fr  <= sat_data(64'(s12_fr >>> COEF_FRAC));

        // Terms, adder tree and final saturation.
        r_term[0] <= s13_t0 >>> FRAC_BITS;
        r_term[1] <= s13_t1 >>> FRAC_BITS;
        r_term[2] <= s13_t2 >>> FRAC_BITS;
        r_term[3] <= s13_t3 >>> FRAC_BITS;
        r_term[4] <= s13_t4 >>> FRAC_BITS;
        r_term[5] <= s13_t5 >>> FRAC_BITS;
        r_term[6] <= 64'(s13_w2 >>> COEF_FRAC);
        r_term[7] <= 64'(s13_w3 >>> COEF_FRAC);
        r_term[8] <= 64'(s13_w5 >>> COEF_FRAC);
        r_grp[0]  <= r_term[0] + r_term[1] + r_term[2];
        r_grp[1]  <= r_term[3] + r_term[4] + r_term[5];
        r_grp[2]  <= r_term[6] + r_term[7] + r_term[8];
        r_sum     <= r_grp[0] + r_grp[1] + r_grp[2];
        r_ham     <= sat_data(-r_sum);
    end

    assign o_valid     = r_vld[PIPE_DEPTH];
    assign o_ham_value = r_ham;
    assign o_last_out  = r_lst[PIPE_DEPTH];

endmodule

// ===== src/vrh_checker.sv =====
// Port-level checker for the vessel reach Hamiltonian block, with its bind.
`include "assert_macros.svh"

module vrh_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_point,
    input logic o_valid,
    input logic o_last_out
);
    import vrh_pkg::*;

    // Every accepted word comes out after the fixed pipeline latency.
    `VRH_ASSERT_PROP(a_accept_to_result, i_clk, i_rst_n, (start && !busy) |-> ##PIPE_DEPTH o_valid)

    // No result word appears without a word accepted out of reset.
    `VRH_ASSERT_PROP(a_result_has_source, i_clk, i_rst_n, o_valid |-> $past(start && !busy && i_rst_n, PIPE_DEPTH))

    // The batch flag travels with its own word.
    `VRH_ASSERT_PROP(a_last_follows, i_clk, i_rst_n, o_valid |-> (o_last_out == $past(i_last_point, PIPE_DEPTH)))

    // The pipeline never refuses a word.
    `VRH_ASSERT_ALWAYS(a_never_busy, i_clk, i_rst_n, !busy)

endmodule

bind vessel_reach_hamiltonian vrh_checker u_vrh_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the vessel reach Hamiltonian block.
module tb_top;
    import vrh_pkg::*;

    // One grid point as offered to the block.
    typedef struct packed {
        t_data grad_x;
        t_data grad_y;
        t_data grad_surge;
        t_data grad_sway;
        t_data grad_heading;
        t_data grad_yaw;
        t_data surge;
        t_data sway;
        t_data heading;
        t_data yaw_rate;
        logic  last;
    } vessel_point_t;

    // One result word as it should come out.
    typedef struct packed {
        t_data ham;
        logic  last;
    } ham_word_t;

    localparam logic [63:0] Q30_ONE = 64'd1 << TRIG_FRAC;
    localparam t_data Q_MAX = 32'sh7fffffff;
    localparam t_data Q_MIN = 32'sh80000000;
    localparam t_coef COEF_FULL = 20'hfffff;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    vessel_point_t cur_pt = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    t_coef i_cfg_data = '0;
    logic o_valid;
    t_data o_ham_value;
    logic o_last_out;

    // The testbench's own copy of the eight coefficient registers.
    t_coef coef_shadow [NUM_REGS];

    vessel_point_t point_q [$];
    ham_word_t ham_expected_q [$];
    int mismatch_cnt = 0;

    // Sender burst shaping.
    int burst_left = 8;
    int gap_left = 0;

    vessel_reach_hamiltonian dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_grad_x       (cur_pt.grad_x),
        .i_grad_y       (cur_pt.grad_y),
        .i_grad_surge   (cur_pt.grad_surge),
        .i_grad_sway    (cur_pt.grad_sway),
        .i_grad_heading (cur_pt.grad_heading),
        .i_grad_yaw     (cur_pt.grad_yaw),
        .i_surge_speed  (cur_pt.surge),
        .i_sway_speed   (cur_pt.sway),
        .i_heading      (cur_pt.heading),
        .i_yaw_rate     (cur_pt.yaw_rate),
        .i_last_point   (cur_pt.last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_ham_value    (o_ham_value),
        .o_last_out     (o_last_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Clamp a 64-bit intermediate to the signed 32-bit data range.
    function automatic logic signed [63:0] clamp_q(input logic signed [63:0] x);
        if (x > 64'sh7fffffff) begin
            return 64'sh7fffffff;
        end
        if (x < -64'sh80000000) begin
            return -64'sh80000000;
        end
        return x;
    endfunction

    function automatic logic signed [63:0] abs64(input logic signed [63:0] x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic signed [63:0] coef64(input t_coef c);
        return $signed({44'd0, c});
    endfunction

    // Expected Hamiltonian of one grid point under the current coefficients.
    function automatic t_data hamiltonian_of(input vessel_point_t pt);
        logic [63:0] prod, x, xr, x2, t, s, c, tmp;
        logic [31:0] phase;
        logic mirror;
        logic signed [63:0] sn, cs, u, v, psi, r, fx, fy, uu, fu, fv, rr, fr, sum;
        logic signed [63:0] p0, p1, p2, p3, p4, p5;
        u = pt.surge;
        v = pt.sway;
        psi = pt.heading;
        r = pt.yaw_rate;
        p0 = pt.grad_x;
        p1 = pt.grad_y;
        p2 = pt.grad_surge;
        p3 = pt.grad_sway;
        p4 = pt.grad_heading;
        p5 = pt.grad_yaw;

        // Heading to a phase in turns; wraps modulo one full turn.
        prod = $unsigned(psi) * 64'd683565276;
        phase = prod[FRAC_BITS +: 32];

        // Fold into the first eighth of a turn, then Taylor polynomials in Q30.
        mirror = phase[29];
        x = mirror ? Q30_ONE - {34'd0, phase[29:0]} : {34'd0, phase[29:0]};
        xr = (x * 64'd1686629713) >> 30;
        x2 = (xr * xr) >> 30;
        t = Q30_ONE - x2 / 42;
        t = Q30_ONE - ((x2 * t) >> 30) / 20;
        t = Q30_ONE - ((x2 * t) >> 30) / 6;
        s = (xr * t) >> 30;
        t = Q30_ONE - x2 / 56;
        t = Q30_ONE - ((x2 * t) >> 30) / 30;
        t = Q30_ONE - ((x2 * t) >> 30) / 12;
        c = Q30_ONE - ((x2 * t) >> 30) / 2;
        if (mirror) begin
            tmp = s;
            s = c;
            c = tmp;
        end
        case (t_quad'(phase[31:30]))
            QUAD_I: begin
                sn = $signed(s);
                cs = $signed(c);
            end
            QUAD_II: begin
                sn = $signed(c);
                cs = -$signed(s);
            end
            QUAD_III: begin
                sn = -$signed(s);
                cs = -$signed(c);
            end
            default: begin
                sn = -$signed(c);
                cs = $signed(s);
            end
        endcase

        fx = clamp_q((u * cs - v * sn) >>> TRIG_FRAC);
        fy = clamp_q((u * sn + v * cs) >>> TRIG_FRAC);
        uu = clamp_q((abs64(u) * u) >>> FRAC_BITS);
        fu = clamp_q((-(coef64(coef_shadow[REG_SURGE_LIN]) * u)
                      - coef64(coef_shadow[REG_SURGE_QUAD]) * uu) >>> COEF_FRAC);
        fv = clamp_q((-(coef64(coef_shadow[REG_SWAY]) * v)) >>> COEF_FRAC);
        rr = clamp_q((abs64(r) * r) >>> FRAC_BITS);
        fr = clamp_q((-(coef64(coef_shadow[REG_YAW_LIN]) * r)
                      - coef64(coef_shadow[REG_YAW_QUAD]) * rr) >>> COEF_FRAC);

        sum = ((fx * p0) >>> FRAC_BITS) + ((fy * p1) >>> FRAC_BITS)
            + ((fu * p2) >>> FRAC_BITS) + ((fv * p3) >>> FRAC_BITS)
            + ((r * p4) >>> FRAC_BITS) + ((fr * p5) >>> FRAC_BITS)
            + ((coef64(coef_shadow[REG_SURGE_DIST]) * abs64(p2)) >>> COEF_FRAC)
            + ((coef64(coef_shadow[REG_SWAY_DIST]) * abs64(p3)) >>> COEF_FRAC)
            + ((coef64(coef_shadow[REG_YAW_DIST]) * abs64(p5)) >>> COEF_FRAC);
        return t_data'(clamp_q(-sum));
    endfunction

    // Random data value, biased toward extremes and physically small values.
    function automatic t_data rand_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            1, 2, 3: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            4, 5: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic vessel_point_t rand_point();
        vessel_point_t pt;
        pt.grad_x = rand_value();
        pt.grad_y = rand_value();
        pt.grad_surge = rand_value();
        pt.grad_sway = rand_value();
        pt.grad_heading = rand_value();
        pt.grad_yaw = rand_value();
        pt.surge = rand_value();
        pt.sway = rand_value();
        pt.heading = ($urandom_range(0, 1) == 0) ? rand_value() : $signed($urandom);
        pt.yaw_rate = rand_value();
        pt.last = ($urandom_range(0, 7) == 0);
        return pt;
    endfunction

    // Directed point: the gradients alternate between g and -g.
    function automatic vessel_point_t shaped_point(input t_data g, input t_data u,
                                                   input t_data v, input t_data psi,
                                                   input t_data r, input logic last);
        vessel_point_t pt;
        pt.grad_x = g;
        pt.grad_y = -g;
        pt.grad_surge = g;
        pt.grad_sway = -g;
        pt.grad_heading = g;
        pt.grad_yaw = -g;
        pt.surge = u;
        pt.sway = v;
        pt.heading = psi;
        pt.yaw_rate = r;
        pt.last = last;
        return pt;
    endfunction

    // Driver: pops pending points in bursts separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                ham_expected_q.push_back('{ham: hamiltonian_of(cur_pt), last: cur_pt.last});
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end else if (point_q.size() > 0) begin
                    cur_pt <= point_q.pop_front();
                    start <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        ham_word_t want;
        if (i_rst_n && o_valid) begin
            if (ham_expected_q.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10) begin
                    $display("unexpected result word: ham %0d last %0b",
                             o_ham_value, o_last_out);
                end
            end else begin
                want = ham_expected_q.pop_front();
                if (o_ham_value !== want.ham || o_last_out !== want.last) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10) begin
                        $display("mismatch: ham exp %0d got %0d, last exp %0b got %0b",
                                 want.ham, o_ham_value, want.last, o_last_out);
                    end
                end
            end
        end
    end

    // Register write; valid stays high so back-to-back writes need no lowering.
    task automatic write_coef(input int idx, input t_coef val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx[CFG_IDX_W-1:0];
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx < NUM_REGS) begin
            coef_shadow[idx] = val;
        end
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold off until all points are sent and every expected result has come back, then let the pipeline settle.
    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((point_q.size() > 0 || start || ham_expected_q.size() > 0)
               && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        repeat (n) point_q.push_back(rand_point());
    endtask

    initial begin
        for (int i = 0; i < NUM_REGS; i++) begin
            coef_shadow[i] = COEF_RESET[i];
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults from reset: directed corners first. Headings hit quadrant
        // edges (0, pi/2, pi, -pi/2, 3pi/2, 2pi) and the eighth-turn mirror point.
        point_q.push_back(shaped_point(0, 0, 0, 0, 0, 1'b0));
        point_q.push_back(shaped_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
        point_q.push_back(shaped_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
        point_q.push_back(shaped_point(Q_MAX, Q_MIN, Q_MAX, 0, Q_MIN, 1'b1));
        point_q.push_back(shaped_point(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b0));
        point_q.push_back(shaped_point(32'sh10000, 32'sh20000, 32'sh8000, 0, 32'sh4000, 1'b0));
        point_q.push_back(shaped_point(32'sh10000, 32'sh20000, 32'sh8000, 32'sd102944,
                                       32'sh4000, 1'b0));
        point_q.push_back(shaped_point(32'sh10000, 32'sh20000, 32'sh8000, 32'sd205887,
                                       -32'sh4000, 1'b1));
        point_q.push_back(shaped_point(32'sh10000, -32'sh20000, 32'sh8000, -32'sd102944,
                                       32'sh4000, 1'b0));
        point_q.push_back(shaped_point(-32'sh10000, 32'sh20000, -32'sh8000, 32'sd308831,
                                       32'sh4000, 1'b0));
        point_q.push_back(shaped_point(32'sh10000, 32'sh20000, 32'sh8000, 32'sd51472,
                                       32'sh4000, 1'b1));
        point_q.push_back(shaped_point(32'sh10000, 32'sh20000, 32'sh8000, 32'sd51471,
                                       32'sh4000, 1'b0));
        point_q.push_back(shaped_point(32'sh10000, 32'sh20000, 32'sh8000, 32'sd411775,
                                       32'sh4000, 1'b0));
        point_q.push_back(shaped_point(Q_MAX, 32'sh7fff, 32'sh7fff, Q_MAX, 32'sh7fff, 1'b1));
        point_q.push_back(shaped_point(Q_MIN, -32'sh7fff, 32'sh100, Q_MIN, -32'sh7fff, 1'b0));
        point_q.push_back(shaped_point(32'sh50000, 0, 32'sh30000, 32'sh18000, 0, 1'b1));
        queue_random(220);
        wait_drained();

        // Every coefficient at full scale; writes past the last index are dropped.
        for (int i = 0; i < NUM_REGS; i++) begin
            write_coef(i, COEF_FULL);
        end
        write_coef(NUM_REGS, 20'h12345);
        write_coef(2 * NUM_REGS - 1, 20'h0);
        cfg_release();
        point_q.push_back(shaped_point(Q_MAX, Q_MAX, Q_MIN, 0, Q_MAX, 1'b1));
        point_q.push_back(shaped_point(Q_MIN, Q_MIN, Q_MAX, 0, Q_MIN, 1'b0));
        queue_random(230);
        wait_drained();

        // All coefficients zero: only the kinematic terms remain.
        for (int i = 0; i < NUM_REGS; i++) begin
            write_coef(i, '0);
        end
        cfg_release();
        queue_random(230);
        wait_drained();

        // A few random settings, each with its own batch of points.
        repeat (3) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                write_coef(i, t_coef'($urandom));
            end
            cfg_release();
            queue_random(85);
            wait_drained();
        end

        if (mismatch_cnt == 0 && ham_expected_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
